// ===== rtl/core/bps_pkg.sv =====
// Package for the bucketed priority stack.
// Holds field widths, operation and error codes, and the controller/datapath interface types.
// No dependencies.
`timescale 1ns / 1ps

package bps_pkg;

  localparam int NUM_LEVELS_DEF = 16;
  localparam int POOL_DEPTH_DEF = 256;
  localparam int VALUE_WIDTH    = 32;

  localparam int OP_WIDTH    = 2;
  localparam int LEVEL_WIDTH = 8;
  localparam int HL_WIDTH    = 4;
  localparam int TOPL_WIDTH  = 4;
  localparam int COUNT_WIDTH = 9;
  localparam int ERR_WIDTH   = 2;

  localparam int IN_TDATA_WIDTH  = 48;
  localparam int OUT_TDATA_WIDTH = 48;

  localparam logic [HL_WIDTH-1:0] HIGHEST_LEVEL_RST = 4'd15;

  localparam logic [OP_WIDTH-1:0] OP_PUSH   = 2'd0;
  localparam logic [OP_WIDTH-1:0] OP_POP    = 2'd1;
  localparam logic [OP_WIDTH-1:0] OP_STATUS = 2'd2;

  localparam logic [ERR_WIDTH-1:0] ERR_NONE      = 2'd0;
  localparam logic [ERR_WIDTH-1:0] ERR_POP_EMPTY = 2'd1;
  localparam logic [ERR_WIDTH-1:0] ERR_PUSH_FULL = 2'd2;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_ACCEPT,
    CMD_PUSH_RD,
    CMD_PUSH_WR,
    CMD_POP_RD_HEAD,
    CMD_POP_RD_LINK,
    CMD_POP_WR,
    CMD_TOP_RD_HEAD,
    CMD_TOP_RD_VAL,
    CMD_RESULT
  } cmd_e;

  typedef struct packed {
    cmd_e step;
  } bps_cmd_t;

  typedef struct packed {
    logic in_valid;
    logic push_go;
    logic pop_go;
    logic any_nonempty;
    logic out_free;
  } bps_status_t;

endpackage

// ===== rtl/core/bps_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module bps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/bps_datapath.sv =====
// Datapath of the bucketed priority stack: item registers, free list, counters,
// bucket-head and node memories, top search and the result register.
// Depends on bps_pkg and bps_ram.
`timescale 1ns / 1ps

module bps_datapath #(
  parameter int NUM_LEVELS = bps_pkg::NUM_LEVELS_DEF,
  parameter int POOL_DEPTH = bps_pkg::POOL_DEPTH_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  input  logic [bps_pkg::HL_WIDTH-1:0]         cfg_data_i,
  input  logic                                 s_axis_tvalid,
  input  logic [bps_pkg::IN_TDATA_WIDTH-1:0]   s_axis_tdata,
  input  logic [bps_pkg::OP_WIDTH-1:0]         s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [bps_pkg::OUT_TDATA_WIDTH-1:0]  m_axis_tdata,
  input  bps_pkg::bps_cmd_t                    cmd_i,
  output bps_pkg::bps_status_t                 status_o
);

  localparam int LW = $clog2(NUM_LEVELS);
  localparam int IW = $clog2(POOL_DEPTH);
  localparam int CW = $clog2(POOL_DEPTH + 1);
  localparam int VW = bps_pkg::VALUE_WIDTH;
  localparam int LVW = bps_pkg::LEVEL_WIDTH;

  logic [bps_pkg::HL_WIDTH-1:0] hl_q;
  logic [VW-1:0]                val_q;
  logic [LW-1:0]                lvl_q;
  logic [bps_pkg::ERR_WIDTH-1:0] err_q, err_d;
  logic [IW-1:0]                node_q;
  logic [IW-1:0]                free_head_q;
  logic                         flv_q;
  logic [CW-1:0]                fresh_q;
  logic [CW-1:0]                count_q;
  logic [NUM_LEVELS-1:0]        nonempty_q;
  logic [LW-1:0]                top_q, top_d;
  logic                         any_q, any_d;

  logic                         out_valid_q;
  logic [bps_pkg::OUT_TDATA_WIDTH-1:0] out_data_q;

  logic [VW-1:0]  val_in;
  logic [LVW-1:0] lvl_in, lvl_hl, lvl_cl;
  logic           in_push, in_pop, full, push_go, pop_go, out_free;

  logic           head_we, head_re;
  logic [LW-1:0]  head_waddr, head_raddr;
  logic [IW-1:0]  head_wdata, head_rdata;
  logic           link_we, link_re;
  logic [IW-1:0]  link_waddr, link_raddr;
  logic [IW:0]    link_wdata, link_rdata;
  logic           vmem_we, vmem_re;
  logic [IW-1:0]  vmem_waddr, vmem_raddr;
  logic [VW-1:0]  vmem_rdata;

  logic [IW-1:0]  push_node;
  logic [LVW-1:0] top_wide;
  logic [VW-1:0]  res_value;

  assign val_in  = s_axis_tdata[VW-1:0];
  assign lvl_in  = s_axis_tdata[VW+LVW-1:VW];
  assign lvl_hl  = (lvl_in > LVW'(hl_q)) ? LVW'(hl_q) : lvl_in;
  assign lvl_cl  = (lvl_hl > LVW'(NUM_LEVELS - 1)) ? LVW'(NUM_LEVELS - 1) : lvl_hl;

  assign in_push  = (s_axis_tuser == bps_pkg::OP_PUSH);
  assign in_pop   = (s_axis_tuser == bps_pkg::OP_POP);
  assign full     = (count_q == CW'(POOL_DEPTH));
  assign push_go  = in_push && !full;
  assign pop_go   = in_pop && (count_q != '0) && any_q;
  assign out_free = !out_valid_q || m_axis_tready;

  always_comb begin
    err_d = bps_pkg::ERR_NONE;
    if (in_push && full) begin
      err_d = bps_pkg::ERR_PUSH_FULL;
    end else if (in_pop && !pop_go) begin
      err_d = bps_pkg::ERR_POP_EMPTY;
    end
  end

  assign status_o.in_valid     = s_axis_tvalid;
  assign status_o.push_go      = push_go;
  assign status_o.pop_go       = pop_go;
  assign status_o.any_nonempty = any_d;
  assign status_o.out_free     = out_free;

  always_comb begin
    top_d = '0;
    any_d = 1'b0;
    for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
      if (nonempty_q[i]) begin
        top_d = LW'(i);
        any_d = 1'b1;
      end
    end
  end

  assign push_node = flv_q ? free_head_q : fresh_q[IW-1:0];

  always_comb begin
    head_we    = 1'b0;
    head_waddr = lvl_q;
    head_wdata = push_node;
    head_re    = 1'b0;
    head_raddr = top_q;
    link_we    = 1'b0;
    link_waddr = push_node;
    link_wdata = {nonempty_q[lvl_q], head_rdata};
    link_re    = 1'b0;
    link_raddr = free_head_q;
    vmem_we    = 1'b0;
    vmem_waddr = push_node;
    vmem_re    = 1'b0;
    vmem_raddr = head_rdata;
    case (cmd_i.step)
      bps_pkg::CMD_PUSH_RD: begin
        head_re    = 1'b1;
        head_raddr = lvl_q;
        link_re    = 1'b1;
      end
      bps_pkg::CMD_PUSH_WR: begin
        head_we = 1'b1;
        link_we = 1'b1;
        vmem_we = 1'b1;
      end
      bps_pkg::CMD_POP_RD_HEAD: begin
        head_re = 1'b1;
      end
      bps_pkg::CMD_POP_RD_LINK: begin
        link_re    = 1'b1;
        link_raddr = head_rdata;
      end
      bps_pkg::CMD_POP_WR: begin
        head_we    = link_rdata[IW];
        head_waddr = top_q;
        head_wdata = link_rdata[IW-1:0];
        link_we    = 1'b1;
        link_waddr = node_q;
        link_wdata = {flv_q, free_head_q};
      end
      bps_pkg::CMD_TOP_RD_HEAD: begin
        head_re = 1'b1;
      end
      bps_pkg::CMD_TOP_RD_VAL: begin
        vmem_re = 1'b1;
      end
      default: begin
      end
    endcase
  end

  bps_ram #(.WIDTH(IW), .DEPTH(NUM_LEVELS)) u_head_ram (
    .clk_i   (clk_i),
    .we_i    (head_we),
    .waddr_i (head_waddr),
    .wdata_i (head_wdata),
    .re_i    (head_re),
    .raddr_i (head_raddr),
    .rdata_o (head_rdata)
  );

  bps_ram #(.WIDTH(IW + 1), .DEPTH(POOL_DEPTH)) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (link_we),
    .waddr_i (link_waddr),
    .wdata_i (link_wdata),
    .re_i    (link_re),
    .raddr_i (link_raddr),
    .rdata_o (link_rdata)
  );

  bps_ram #(.WIDTH(VW), .DEPTH(POOL_DEPTH)) u_value_ram (
    .clk_i   (clk_i),
    .we_i    (vmem_we),
    .waddr_i (vmem_waddr),
    .wdata_i (val_q),
    .re_i    (vmem_re),
    .raddr_i (vmem_raddr),
    .rdata_o (vmem_rdata)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.step == bps_pkg::CMD_ACCEPT && s_axis_tvalid) begin
      val_q <= val_in;
      lvl_q <= lvl_cl[LW-1:0];
      err_q <= err_d;
    end
    if (cmd_i.step == bps_pkg::CMD_POP_RD_LINK) begin
      node_q <= head_rdata;
    end
  end

  assign top_wide  = LVW'(top_q);
  assign res_value = any_q ? vmem_rdata : '0;

  always_ff @(posedge clk_i) begin
    if (cmd_i.step == bps_pkg::CMD_RESULT && out_free) begin
      out_data_q <= {err_q,
                     (count_q == '0),
                     bps_pkg::COUNT_WIDTH'(count_q),
                     any_q ? top_wide[bps_pkg::TOPL_WIDTH-1:0] : bps_pkg::TOPL_WIDTH'(0),
                     res_value};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hl_q        <= bps_pkg::HIGHEST_LEVEL_RST;
      free_head_q <= '0;
      flv_q       <= 1'b0;
      fresh_q     <= '0;
      count_q     <= '0;
      nonempty_q  <= '0;
      top_q       <= '0;
      any_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      top_q <= top_d;
      any_q <= any_d;
      if (cfg_valid_i) begin
        hl_q <= cfg_data_i;
      end
      case (cmd_i.step)
        bps_pkg::CMD_PUSH_WR: begin
          nonempty_q[lvl_q] <= 1'b1;
          count_q           <= count_q + CW'(1);
          if (flv_q) begin
            flv_q       <= link_rdata[IW];
            free_head_q <= link_rdata[IW-1:0];
          end else begin
            fresh_q <= fresh_q + CW'(1);
          end
        end
        bps_pkg::CMD_POP_WR: begin
          if (!link_rdata[IW]) begin
            nonempty_q[top_q] <= 1'b0;
          end
          free_head_q <= node_q;
          flv_q       <= 1'b1;
          count_q     <= count_q - CW'(1);
        end
        default: begin
        end
      endcase
      if (cmd_i.step == bps_pkg::CMD_RESULT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

// ===== rtl/core/bps_ctrl.sv =====
// Controller of the bucketed priority stack: sequences memory reads and writes per word.
// Depends on bps_pkg.
`timescale 1ns / 1ps

module bps_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  bps_pkg::bps_status_t status_i,
  output bps_pkg::bps_cmd_t    cmd_o,
  output logic                 s_axis_tready
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PUSH_RD,
    ST_PUSH_WR,
    ST_POP_RD_HEAD,
    ST_POP_RD_LINK,
    ST_POP_WR,
    ST_SETTLE,
    ST_TOP_RD_HEAD,
    ST_TOP_RD_VAL,
    ST_RESULT
  } state_e;

  state_e state_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (status_i.in_valid) begin
            if (status_i.push_go) begin
              state_q <= ST_PUSH_RD;
            end else if (status_i.pop_go) begin
              state_q <= ST_POP_RD_HEAD;
            end else begin
              state_q <= ST_SETTLE;
            end
          end
        end
        ST_PUSH_RD:     state_q <= ST_PUSH_WR;
        ST_PUSH_WR:     state_q <= ST_SETTLE;
        ST_POP_RD_HEAD: state_q <= ST_POP_RD_LINK;
        ST_POP_RD_LINK: state_q <= ST_POP_WR;
        ST_POP_WR:      state_q <= ST_SETTLE;
        ST_SETTLE: begin
          state_q <= status_i.any_nonempty ? ST_TOP_RD_HEAD : ST_RESULT;
        end
        ST_TOP_RD_HEAD: state_q <= ST_TOP_RD_VAL;
        ST_TOP_RD_VAL:  state_q <= ST_RESULT;
        ST_RESULT: begin
          if (status_i.out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_comb begin
    case (state_q)
      ST_IDLE:        cmd_o.step = bps_pkg::CMD_ACCEPT;
      ST_PUSH_RD:     cmd_o.step = bps_pkg::CMD_PUSH_RD;
      ST_PUSH_WR:     cmd_o.step = bps_pkg::CMD_PUSH_WR;
      ST_POP_RD_HEAD: cmd_o.step = bps_pkg::CMD_POP_RD_HEAD;
      ST_POP_RD_LINK: cmd_o.step = bps_pkg::CMD_POP_RD_LINK;
      ST_POP_WR:      cmd_o.step = bps_pkg::CMD_POP_WR;
      ST_TOP_RD_HEAD: cmd_o.step = bps_pkg::CMD_TOP_RD_HEAD;
      ST_TOP_RD_VAL:  cmd_o.step = bps_pkg::CMD_TOP_RD_VAL;
      ST_RESULT:      cmd_o.step = bps_pkg::CMD_RESULT;
      default:        cmd_o.step = bps_pkg::CMD_NONE;
    endcase
  end

  assign s_axis_tready = (state_q == ST_IDLE);

endmodule

// ===== rtl/core/bucketed_priority_stack.sv =====
// Bucketed priority stack: one word in, one result word out per operation.
// A status word, or one that ends in an error, goes from acceptance through settle, the
// head and value reads (not when the stack is empty) and result; a push adds read and
// write steps, a pop head, link and write steps. New words wait for the result register.
// The result register lets the next word be accepted while a result waits.
// Asynchronous active-low reset empties the stack and sets highest_level to 15.
`timescale 1ns / 1ps

module bucketed_priority_stack #(
  parameter int NUM_LEVELS = bps_pkg::NUM_LEVELS_DEF,
  parameter int POOL_DEPTH = bps_pkg::POOL_DEPTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [bps_pkg::HL_WIDTH-1:0]        cfg_data_i,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // value_in [31:0], level_in [39:32], zeros [47:40].
  input  logic [bps_pkg::IN_TDATA_WIDTH-1:0]  s_axis_tdata,
  // operation [1:0].
  input  logic [bps_pkg::OP_WIDTH-1:0]        s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // top_value [31:0], top_level [35:32], count [44:36], is_empty [45], error_code [47:46].
  output logic [bps_pkg::OUT_TDATA_WIDTH-1:0] m_axis_tdata
);

  bps_pkg::bps_cmd_t    cmd;
  bps_pkg::bps_status_t status;

  assign cfg_ready_o = 1'b1;

  bps_datapath #(
    .NUM_LEVELS (NUM_LEVELS),
    .POOL_DEPTH (POOL_DEPTH)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cmd_i         (cmd),
    .status_o      (status)
  );

  bps_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .status_i      (status),
    .cmd_o         (cmd),
    .s_axis_tready (s_axis_tready)
  );

endmodule
